>>> sv/mpbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbt_pkg: shared types and constants of the multi-pin blink timer
// Command codes, field widths, the stored entry layout and the divider
// status bundle.
// ----------------------------------------------------------------------------
package mpbt_pkg;

  localparam int PIN_W       = 5;
  localparam int MS_W        = 16;
  localparam int TICK_W      = 13;
  localparam int TICK_MAX    = 8191;
  localparam int PIN_SLOTS   = 32;

  localparam int PIN_COUNT_DEF   = 32;
  localparam int MS_PER_TICK_DEF = 10;

  typedef enum logic [2:0] {
    K_CONFIG      = 3'd0,
    K_START       = 3'd1,
    K_STOP        = 3'd2,
    K_STOP_DRIVE  = 3'd3,
    K_CLEAR       = 3'd4,
    K_CLEAR_DRIVE = 3'd5,
    K_TICK        = 3'd6
  } kind_t;

  typedef struct packed {
    logic [TICK_W-1:0] on_ticks;
    logic [TICK_W-1:0] off_ticks;
    logic [TICK_W-1:0] countdown;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/mpbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mpbt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbt_div: divider by a constant through reciprocal multiplication
// Divides a millisecond value by the tick length with one registered
// multiply by a precomputed reciprocal and saturates the quotient to the
// tick range. The result is ready the cycle after start.
// ----------------------------------------------------------------------------
module mpbt_div import mpbt_pkg::*; #(
  parameter int DIVISOR = MS_PER_TICK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MS_W-1:0]   dividend,
  output div_stat_t         stat,
  output logic [TICK_W-1:0] quot
);

  // (x * RECIP) >> SHIFT equals x / DIVISOR for every MS_W-bit x when
  // SHIFT = MS_W + ceil(log2(DIVISOR)) and RECIP = ceil(2^SHIFT / DIVISOR)
  localparam int     LOG_D   = $clog2(DIVISOR);
  localparam int     SHIFT   = MS_W + LOG_D;
  localparam int     RW      = MS_W + 1;
  localparam int     PW      = MS_W + RW;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [PW-1:0] SAT_C = PW'(TICK_MAX);

  logic [PW-1:0] prod;
  logic [PW-1:0] qfull;
  logic          done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{RW{1'b0}}, dividend} * {{MS_W{1'b0}}, RECIP};
    end
  end

  assign qfull     = prod >> SHIFT;
  assign stat.busy = done;
  assign stat.done = done;
  assign quot      = (qfull > SAT_C) ? TICK_W'(TICK_MAX) : qfull[TICK_W-1:0];

endmodule

>>> sv/multi_pin_blink_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pin_blink_timer_core: per-pin blink engine
// Commands configure, start, stop and clear pin entries; a tick walks all
// entries and emits one pin write for each entry whose countdown expires.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command item: tuser holds the kind, tdata the
//   pin, on and off periods in ms, and a level. Master stream carries pin
//   writes: tdata holds pin and level, tlast marks the final write of a
//   command. One item is worked on at a time; s_tready is high only idle.
//   Steps per item:
//     stop, clear: done at accept (drive variants then load the output register)
//     start: entry read, then write back
//     configure: accept, then the shared reciprocal multiplier converts
//       the on period and then the off period
//     tick: one entry per cycle through the entry RAM port unless the
//       output stalls, over DEPTH = min(PIN_COUNT, 32) entries, then a flush.
//   A tick holds one write back in a pending register so that tlast can be
//   set on the last one. When m_tready stays low, the walk stalls on the
//   next expiring entry until the output register frees up.
//   Reset clears all enables, levels and entry valid flags at once; the
//   entry RAM needs no clearing pass and the block is ready right after.
// ----------------------------------------------------------------------------
module multi_pin_blink_timer_core import mpbt_pkg::*; #(
  parameter int PIN_COUNT   = PIN_COUNT_DEF,
  parameter int MS_PER_TICK = MS_PER_TICK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pin[4:0], on_ms[20:5], off_ms[36:21], level[37]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_pin[4:0], out_level[5]
  output logic        m_tlast
);

  localparam int DEPTH = (PIN_COUNT < PIN_SLOTS) ? PIN_COUNT : PIN_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_CFG_ON,
    ST_CFG_OFF,
    ST_TICK,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t            state;
  kind_t             in_kind;
  logic [PIN_W-1:0]  in_pin;
  logic [AW-1:0]     in_idx;
  logic              pin_ok;
  logic              acc;

  logic [AW-1:0]     cmd_pin;
  logic              cmd_level;
  logic [MS_W-1:0]   cmd_on_ms;
  logic [MS_W-1:0]   cmd_off_ms;
  logic [TICK_W-1:0] cfg_on_ticks;
  logic [AW-1:0]     idx;

  logic [DEPTH-1:0]  chan_enabled;
  logic [DEPTH-1:0]  chan_level;
  logic [DEPTH-1:0]  entry_valid;

  logic              out_valid;
  logic [PIN_W-1:0]  out_pin;
  logic              out_level;
  logic              out_last;
  logic              pend_valid;
  logic [PIN_W-1:0]  pend_pin;
  logic              pend_level;

  logic              div_start;
  logic [MS_W-1:0]   div_dividend;
  div_stat_t         div_stat;
  logic [TICK_W-1:0] div_quot;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  entry_t            eff;
  logic [AW-1:0]     eff_idx;

  logic              t_en;
  logic [TICK_W-1:0] t_cnt1;
  logic              t_fire;
  logic              t_lvl;
  logic [TICK_W-1:0] t_cnt;
  logic              t_stall;
  logic              out_free;

  assign in_kind  = kind_t'(s_tuser);
  assign in_pin   = s_tdata[4:0];
  assign in_idx   = in_pin[AW-1:0];
  assign pin_ok   = (32'(in_pin) < 32'(DEPTH));
  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // an entry never written reads as all zero
  assign eff_idx = (state == ST_TICK) ? idx : cmd_pin;
  assign eff     = entry_valid[eff_idx] ? ram_rdata : '0;

  assign t_en    = chan_enabled[idx];
  assign t_cnt1  = (eff.countdown != '0) ? (eff.countdown - TICK_W'(1)) : '0;
  assign t_fire  = t_en && (t_cnt1 == '0);
  assign t_lvl   = ~chan_level[idx];
  assign t_cnt   = t_fire ? (t_lvl ? eff.on_ticks : eff.off_ticks) : t_cnt1;
  assign t_stall = (state == ST_TICK) && t_fire && pend_valid && !out_free;

  assign div_dividend = (state == ST_CFG_OFF) ? cmd_off_ms : cmd_on_ms;

  always_comb begin
    unique case (state)
      ST_IDLE: ram_raddr = (in_kind == K_TICK) ? '0 : in_idx;
      ST_TICK: begin
        if (t_stall) begin
          ram_raddr = idx;
        end else begin
          ram_raddr = (idx == LAST_IDX) ? '0 : (idx + AW'(1));
        end
      end
      default: ram_raddr = cmd_pin;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_pin;
    ram_wdata = eff;
    unique case (state)
      ST_TICK: begin
        ram_we    = t_en && !t_stall;
        ram_waddr = idx;
        ram_wdata = '{on_ticks: eff.on_ticks, off_ticks: eff.off_ticks, countdown: t_cnt};
      end
      ST_CMD: begin
        ram_we    = 1'b1;
        ram_wdata = '{on_ticks: eff.on_ticks, off_ticks: eff.off_ticks,
                      countdown: cmd_level ? eff.on_ticks : eff.off_ticks};
      end
      ST_CFG_OFF: begin
        ram_we    = div_stat.done;
        ram_wdata = '{on_ticks: cfg_on_ticks, off_ticks: div_quot,
                      countdown: eff.countdown};
      end
      default: ram_we = 1'b0;
    endcase
  end

  mpbt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpbt_div #(
    .DIVISOR (MS_PER_TICK)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chan_enabled <= '0;
      chan_level   <= '0;
      entry_valid  <= '0;
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            cmd_pin    <= in_idx;
            cmd_level  <= s_tdata[37];
            cmd_on_ms  <= s_tdata[20:5];
            cmd_off_ms <= s_tdata[36:21];
            idx        <= '0;
            if (in_kind == K_TICK) begin
              state <= ST_TICK;
            end else if (pin_ok) begin
              unique case (in_kind)
                K_CONFIG: begin
                  div_start <= 1'b1;
                  state     <= ST_CFG_ON;
                end
                K_START: state <= ST_CMD;
                K_STOP: chan_enabled[in_idx] <= 1'b0;
                K_STOP_DRIVE: begin
                  chan_enabled[in_idx] <= 1'b0;
                  state                <= ST_EMIT;
                end
                K_CLEAR: begin
                  chan_enabled[in_idx] <= 1'b0;
                  chan_level[in_idx]   <= 1'b0;
                  entry_valid[in_idx]  <= 1'b0;
                end
                K_CLEAR_DRIVE: begin
                  chan_enabled[in_idx] <= 1'b0;
                  chan_level[in_idx]   <= 1'b0;
                  entry_valid[in_idx]  <= 1'b0;
                  state                <= ST_EMIT;
                end
                default: state <= ST_IDLE;
              endcase
            end
          end
        end
        ST_CMD: begin
          chan_level[cmd_pin]   <= cmd_level;
          chan_enabled[cmd_pin] <= 1'b1;
          entry_valid[cmd_pin]  <= 1'b1;
          state                 <= ST_IDLE;
        end
        ST_CFG_ON: begin
          if (div_stat.done) begin
            cfg_on_ticks <= div_quot;
            div_start    <= 1'b1;
            state        <= ST_CFG_OFF;
          end
        end
        ST_CFG_OFF: begin
          if (div_stat.done) begin
            entry_valid[cmd_pin] <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (!t_stall) begin
            if (t_fire) begin
              chan_level[idx] <= t_lvl;
              // push the older write out; hold the new one until we know if it is last
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_pin   <= pend_pin;
                out_level <= pend_level;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_pin   <= PIN_W'(idx);
              pend_level <= t_lvl;
            end
            if (idx == LAST_IDX) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_pin    <= pend_pin;
            out_level  <= pend_level;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_pin   <= PIN_W'(cmd_pin);
            out_level <= cmd_level;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_level, out_pin};
  assign m_tlast  = out_last;

  // nothing may be left pending once the block takes a new item
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("pending pin write left over at idle");

  // an enabled entry always has a written RAM word behind it
  a_enabled_valid: assert property (@(posedge clk) disable iff (rst)
    (chan_enabled & ~entry_valid) == '0)
    else $error("enabled entry without valid RAM word");

  a_div_in_cfg: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_CFG_ON || state == ST_CFG_OFF))
    else $error("divider running outside configure");

  // a stalled walk must stay on the same entry
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    t_stall |=> (state == ST_TICK) && $stable(idx))
    else $error("tick walk advanced during output stall");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_pin_blink_timer_core
// Sends blink commands on the slave stream and checks every pin write on
// the master stream against a per-pin predictor of the blink engine. Both
// streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import mpbt_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             level;
    logic             last;
  } pin_write_t;

  class pin_write_scoreboard;
    bit                enabled   [PIN_SLOTS];
    bit                level     [PIN_SLOTS];
    bit [TICK_W-1:0]   on_ticks  [PIN_SLOTS];
    bit [TICK_W-1:0]   off_ticks [PIN_SLOTS];
    bit [TICK_W-1:0]   countdown [PIN_SLOTS];
    pin_write_t        expected_writes[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit [TICK_W-1:0] ms_to_ticks(bit [MS_W-1:0] ms);
      int unsigned t;
      t = ms / MS_PER_TICK_DEF;
      if (t > TICK_MAX) t = TICK_MAX;
      return t[TICK_W-1:0];
    endfunction

    function void clear_entry(int p);
      enabled[p]   = 1'b0;
      level[p]     = 1'b0;
      on_ticks[p]  = '0;
      off_ticks[p] = '0;
      countdown[p] = '0;
    endfunction

    function void note_command(logic [2:0] kind, logic [PIN_W-1:0] pin,
                               logic [MS_W-1:0] on_ms, logic [MS_W-1:0] off_ms,
                               logic lvl);
      int toggled[$];
      pin_write_t w;
      case (kind)
        K_TICK: begin
          for (int p = 0; p < PIN_COUNT_DEF; p++) begin
            if (enabled[p]) begin
              if (countdown[p] != 0) countdown[p] = countdown[p] - 1'b1;
              if (countdown[p] == 0) begin
                level[p] = ~level[p];
                countdown[p] = level[p] ? on_ticks[p] : off_ticks[p];
                toggled.push_back(p);
              end
            end
          end
          foreach (toggled[i]) begin
            w.pin   = PIN_W'(toggled[i]);
            w.level = level[toggled[i]];
            w.last  = (i == toggled.size() - 1);
            expected_writes.push_back(w);
          end
        end
        K_CONFIG: begin
          on_ticks[pin]  = ms_to_ticks(on_ms);
          off_ticks[pin] = ms_to_ticks(off_ms);
        end
        K_START: begin
          level[pin]     = lvl;
          countdown[pin] = lvl ? on_ticks[pin] : off_ticks[pin];
          enabled[pin]   = 1'b1;
        end
        K_STOP: enabled[pin] = 1'b0;
        K_STOP_DRIVE: begin
          enabled[pin] = 1'b0;
          w = '{pin: pin, level: lvl, last: 1'b1};
          expected_writes.push_back(w);
        end
        K_CLEAR: clear_entry(pin);
        K_CLEAR_DRIVE: begin
          w = '{pin: pin, level: lvl, last: 1'b1};
          expected_writes.push_back(w);
          clear_entry(pin);
        end
        default: ;
      endcase
    endfunction

    function void check_write(logic [PIN_W-1:0] pin, logic lvl, logic last);
      pin_write_t want;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected write pin=%0d level=%0b last=%0b", $time, pin, lvl, last);
      end else begin
        want = expected_writes.pop_front();
        if (want.pin !== pin || want.level !== lvl || want.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: write mismatch exp pin=%0d level=%0b last=%0b, ",
                      "got pin=%0d level=%0b last=%0b"},
                     $time, want.pin, want.level, want.last, pin, lvl, last);
        end
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // pin[4:0], on_ms[20:5], off_ms[36:21], level[37]
  logic [2:0]  s_tuser = '0;   // kind[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_pin[4:0], out_level[5]
  logic        m_tlast;

  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  pin_write_scoreboard sb = new();

  multi_pin_blink_timer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, a few long ones, none in a steady stretch.
  function automatic int pick_gap(bit steady);
    int r;
    r = int'($urandom_range(0, 99));
    if (steady || r < 50) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 20));
  endfunction

  task automatic send_cmd(input logic [2:0] kind, input logic [PIN_W-1:0] pin,
                          input logic [MS_W-1:0] on_ms, input logic [MS_W-1:0] off_ms,
                          input logic lvl);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, lvl, off_ms, on_ms, pin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(kind, pin, on_ms, off_ms, lvl);
  endtask

  // Mostly short periods so that entries toggle; now and then a full-range one.
  function automatic logic [MS_W-1:0] pick_ms();
    if ($urandom_range(0, 4) == 0) return MS_W'($urandom_range(0, 65535));
    return MS_W'($urandom_range(0, 60));
  endfunction

  task automatic send_random(output bit counted);
    int r;
    logic [2:0] kind;
    r = int'($urandom_range(0, 99));
    if (r < 36)      kind = K_TICK;
    else if (r < 52) kind = K_CONFIG;
    else if (r < 68) kind = K_START;
    else if (r < 76) kind = K_STOP;
    else if (r < 84) kind = K_STOP_DRIVE;
    else if (r < 90) kind = K_CLEAR;
    else if (r < 96) kind = K_CLEAR_DRIVE;
    else             kind = KIND_UNUSED;
    send_cmd(kind, PIN_W'($urandom_range(0, 31)), pick_ms(), pick_ms(),
             1'($urandom_range(0, 1)));
    counted = (kind != KIND_UNUSED);
  endtask

  // Result sink: check each accepted write, then pick the next ready pattern.
  initial begin
    int hold;
    int cycle;
    hold = 0;
    cycle = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_write(m_tdata[4:0], m_tdata[5], m_tlast);
      cycle++;
      if (cycle % 256 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap(sink_steady);
      end
    end
  end

  initial begin
    int done_items;
    bit counted;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero periods, full-range periods, a sub-tick period
    send_cmd(K_CONFIG, 5'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(K_CONFIG, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
    send_cmd(K_CONFIG, 5'd5, 16'd9, 16'd10, 1'b0);
    send_cmd(K_CONFIG, 5'd10, 16'd20, 16'd30, 1'b1);
    send_cmd(K_START, 5'd0, 16'd0, 16'd0, 1'b1);
    send_cmd(K_START, 5'd31, 16'd0, 16'd0, 1'b0);
    send_cmd(K_START, 5'd5, 16'd0, 16'd0, 1'b0);
    send_cmd(K_START, 5'd10, 16'd0, 16'd0, 1'b1);
    // a never-configured entry toggles on every tick
    send_cmd(K_START, 5'd3, 16'd0, 16'd0, 1'b1);
    repeat (4) send_cmd(K_TICK, 5'd17, 16'hFFFF, 16'h0000, 1'b1);
    send_cmd(K_STOP, 5'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(K_STOP_DRIVE, 5'd31, 16'd0, 16'd0, 1'b1);
    send_cmd(K_TICK, 5'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(K_CLEAR, 5'd5, 16'd0, 16'd0, 1'b0);
    send_cmd(K_CLEAR_DRIVE, 5'd0, 16'd0, 16'd0, 1'b1);
    send_cmd(KIND_UNUSED, 5'd3, 16'd0, 16'd0, 1'b1);
    // restart a stopped entry with its periods kept
    send_cmd(K_START, 5'd31, 16'd0, 16'd0, 1'b1);
    send_cmd(K_TICK, 5'd31, 16'd0, 16'd0, 1'b0);
    send_cmd(K_TICK, 5'd0, 16'd0, 16'd0, 1'b0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
      send_random(counted);
      if (counted) done_items++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
sv/mpbt_pkg.sv
sv/mpbt_ram.sv
sv/mpbt_div.sv
sv/multi_pin_blink_timer_core.sv
tb/testbench.sv
